[design/bfea_pkg.sv]
// shared types and constants for the best-fit extent allocator
// no dependencies

package bfea_pkg;

  localparam int unsigned PoolBytes     = 65536;
  localparam int unsigned MaxExtents    = 32;
  localparam int unsigned HeaderBytes   = 8;
  localparam int unsigned MinBlockBytes = 24;

  localparam int unsigned IdxW  = $clog2(MaxExtents);
  localparam int unsigned AddrW = 16;
  localparam int unsigned LenW  = 17;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNoFit    = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;
  localparam logic [1:0] StatusNullFree = 2'd3;

  typedef struct packed {
    logic             mode;
    logic [LenW-1:0]  request_size;
    logic [AddrW-1:0] block_address;
    logic [LenW-1:0]  block_length;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] user_address;
    logic [LenW-1:0]  granted_length;
  } rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StWait,
    StCommit,
    StRespond
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic commit;
    logic rsp_load;
  } ctrl_t;

  typedef struct packed {
    logic scan_last;
  } stat_t;

endpackage

[design/best_fit_extent_allocator_unit.sv]
// Best-fit allocator with coalescing free over a 64 KiB pool, free extents
// kept in a 32-entry table (two small RAMs plus valid flip-flops). Each
// allocate or free occupies the unit through an accept step, a sweep of the
// table one entry a cycle through the RAM read port, a write-back step and
// a step to load the result register. The result register lets the next
// item be accepted while a result waits; that item then stalls in its last
// cycle until the waiting result is taken.
// Entry zero is written while reset is held and in the first cycle after it.
// depends on bfea_pkg, bfea_ctrl, bfea_datapath

module best_fit_extent_allocator_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bfea_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bfea_pkg::rsp_t out_data_o
);

  bfea_pkg::ctrl_t ctrl;
  bfea_pkg::stat_t stat;

  bfea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  bfea_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (in_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rsp_o       (out_data_o)
  );

endmodule

[design/bfea_ram.sv]
// generic single-port-write, single-read ram with registered read
// no dependencies

module bfea_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/bfea_ctrl.sv]
// controller state machine for the extent allocator
// depends on bfea_pkg

module bfea_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  bfea_pkg::stat_t stat_i,
  output bfea_pkg::ctrl_t ctrl_o
);

  bfea_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfea_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // result register may still hold a transfer while the next item scans
  logic rsp_free;
  assign rsp_free = !out_valid_i || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bfea_pkg::StIdle: begin
        if (in_valid_i) state_d = bfea_pkg::StScan;
      end
      bfea_pkg::StScan: begin
        if (stat_i.scan_last) state_d = bfea_pkg::StWait;
      end
      bfea_pkg::StWait:    state_d = bfea_pkg::StCommit;
      bfea_pkg::StCommit:  state_d = bfea_pkg::StRespond;
      bfea_pkg::StRespond: begin
        if (rsp_free) state_d = bfea_pkg::StIdle;
      end
      default: state_d = bfea_pkg::StIdle;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      bfea_pkg::StIdle: begin
        in_ready_o        = 1'b1;
        ctrl_o.load       = in_valid_i;
        ctrl_o.scan_start = in_valid_i;
      end
      bfea_pkg::StScan:    ctrl_o.scan_step = 1'b1;
      bfea_pkg::StWait:    ctrl_o.scan_step = 1'b1;
      bfea_pkg::StCommit:  ctrl_o.commit = 1'b1;
      bfea_pkg::StRespond: ctrl_o.rsp_load = rsp_free;
      default: ;
    endcase
  end

endmodule

[design/bfea_datapath.sv]
// extent table, scan comparators and result register
// depends on bfea_pkg and bfea_ram

module bfea_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bfea_pkg::req_t          req_i,
  input  bfea_pkg::ctrl_t         ctrl_i,
  output bfea_pkg::stat_t         stat_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output bfea_pkg::rsp_t          rsp_o
);

  localparam int unsigned IdxW = bfea_pkg::IdxW;
  localparam int unsigned LenW = bfea_pkg::LenW;
  localparam int unsigned AddrW = bfea_pkg::AddrW;
  localparam logic [LenW-1:0] LenMax = '1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(bfea_pkg::MaxExtents - 1);

  bfea_pkg::req_t req_q;

  // valid bits in flip-flops
  logic [bfea_pkg::MaxExtents-1:0] valid_q, valid_d;

  // scan pipeline: address counter, then registered ram read in the following cycle
  logic [IdxW-1:0] raddr_q;
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            scan_last;

  logic [AddrW-1:0] st_rdata;
  logic [LenW-1:0]  ln_rdata;

  logic             st_we, ln_we;
  logic [IdxW-1:0]  st_waddr, ln_waddr;
  logic [AddrW-1:0] st_wdata;
  logic [LenW-1:0]  ln_wdata;

  bfea_ram #(.Width(AddrW), .Depth(bfea_pkg::MaxExtents)) u_start_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (raddr_q),
    .rdata_o (st_rdata)
  );

  bfea_ram #(.Width(LenW), .Depth(bfea_pkg::MaxExtents)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (ln_we),
    .waddr_i (ln_waddr),
    .wdata_i (ln_wdata),
    .raddr_i (raddr_q),
    .rdata_o (ln_rdata)
  );

  // entry zero at reset: start 0, length pool size, valid; handled by a
  // one-shot init write flag after reset
  logic init_q;

  // per-item derived values
  logic [LenW:0]    need_w;
  logic [LenW:0]    need_q;
  logic [AddrW-1:0] fstart_q;
  logic [LenW:0]    fend_q;

  always_comb begin
    need_w = {1'b0, req_i.request_size} + (LenW+1)'(bfea_pkg::HeaderBytes);
    if (need_w < (LenW+1)'(bfea_pkg::MinBlockBytes)) begin
      need_w = (LenW+1)'(bfea_pkg::MinBlockBytes);
    end
  end

  // search results
  logic             best_f_q, left_f_q, right_f_q, slot_f_q;
  logic [IdxW-1:0]  best_i_q, left_i_q, right_i_q, slot_i_q;
  logic [LenW-1:0]  best_l_q, left_l_q, right_l_q;
  logic [AddrW-1:0] best_s_q;

  logic             ent_vld;
  logic [LenW:0]    ent_end;

  assign ent_vld = valid_q[rd_idx_q];
  assign ent_end = {2'b00, st_rdata} + {1'b0, ln_rdata};
  assign scan_last = (raddr_q == LastIdx);
  assign stat_o.scan_last = scan_last;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_q    <= req_i;
      need_q   <= need_w;
      fstart_q <= req_i.block_address - AddrW'(bfea_pkg::HeaderBytes);
      fend_q   <= {2'b00, req_i.block_address - AddrW'(bfea_pkg::HeaderBytes)}
                  + {1'b0, req_i.block_length};
    end
    if (ctrl_i.scan_start) begin
      best_f_q  <= 1'b0;
      left_f_q  <= 1'b0;
      right_f_q <= 1'b0;
      slot_f_q  <= 1'b0;
    end else if (rd_vld_q) begin
      if (!ent_vld) begin
        if (!slot_f_q) begin
          slot_f_q <= 1'b1;
          slot_i_q <= rd_idx_q;
        end
      end else begin
        if ({1'b0, ln_rdata} >= need_q && (!best_f_q || ln_rdata < best_l_q)) begin
          best_f_q <= 1'b1;
          best_i_q <= rd_idx_q;
          best_l_q <= ln_rdata;
          best_s_q <= st_rdata;
        end
        if (!left_f_q && ent_end == {2'b00, fstart_q}) begin
          left_f_q <= 1'b1;
          left_i_q <= rd_idx_q;
          left_l_q <= ln_rdata;
        end
        if (!right_f_q && {2'b00, st_rdata} == fend_q) begin
          right_f_q <= 1'b1;
          right_i_q <= rd_idx_q;
          right_l_q <= ln_rdata;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raddr_q  <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      if (ctrl_i.scan_start) begin
        raddr_q  <= '0;
        rd_vld_q <= 1'b0;
      end else if (ctrl_i.scan_step) begin
        rd_idx_q <= raddr_q;
        if (!scan_last) raddr_q <= raddr_q + 1'b1;
        rd_vld_q <= 1'b1;
      end else begin
        rd_vld_q <= 1'b0;
      end
    end
  end

  // commit decision
  logic [1:0]       status_c;
  logic [AddrW-1:0] uaddr_c;
  logic [LenW-1:0]  glen_c;
  logic [LenW+1:0]  sum3;
  logic [LenW-1:0]  blen;

  assign blen = req_q.block_length;

  always_comb begin
    valid_d  = valid_q;
    st_we    = 1'b0;
    ln_we    = 1'b0;
    st_waddr = '0;
    ln_waddr = '0;
    st_wdata = '0;
    ln_wdata = '0;
    status_c = bfea_pkg::StatusOk;
    uaddr_c  = '0;
    glen_c   = '0;
    sum3     = '0;
    if (init_q) begin
      st_we       = 1'b1;
      ln_we       = 1'b1;
      st_wdata    = '0;
      ln_wdata    = LenW'(bfea_pkg::PoolBytes);
    end else if (ctrl_i.commit) begin
      if (!req_q.mode) begin
        if (!best_f_q) begin
          status_c = bfea_pkg::StatusNoFit;
        end else begin
          uaddr_c  = best_s_q + AddrW'(bfea_pkg::HeaderBytes);
          glen_c   = need_q[LenW-1:0];
          st_we    = 1'b1;
          ln_we    = 1'b1;
          st_waddr = best_i_q;
          ln_waddr = best_i_q;
          st_wdata = best_s_q + need_q[AddrW-1:0];
          ln_wdata = best_l_q - need_q[LenW-1:0];
          if (best_l_q == need_q[LenW-1:0]) valid_d[best_i_q] = 1'b0;
        end
      end else if (req_q.block_address == '0) begin
        status_c = bfea_pkg::StatusNullFree;
      end else if (blen == '0) begin
        status_c = bfea_pkg::StatusOk;
      end else if (left_f_q) begin
        sum3 = {2'b0, left_l_q} + {2'b0, blen}
             + (right_f_q ? {2'b0, right_l_q} : '0);
        ln_we    = 1'b1;
        ln_waddr = left_i_q;
        ln_wdata = (sum3 > {2'b0, LenMax}) ? LenMax : sum3[LenW-1:0];
        if (right_f_q) valid_d[right_i_q] = 1'b0;
      end else if (right_f_q) begin
        sum3 = {2'b0, right_l_q} + {2'b0, blen};
        st_we    = 1'b1;
        ln_we    = 1'b1;
        st_waddr = right_i_q;
        ln_waddr = right_i_q;
        st_wdata = fstart_q;
        ln_wdata = (sum3 > {2'b0, LenMax}) ? LenMax : sum3[LenW-1:0];
      end else if (!slot_f_q) begin
        status_c = bfea_pkg::StatusFull;
      end else begin
        st_we    = 1'b1;
        ln_we    = 1'b1;
        st_waddr = slot_i_q;
        ln_waddr = slot_i_q;
        st_wdata = fstart_q;
        ln_wdata = blen;
        valid_d[slot_i_q] = 1'b1;
      end
    end
  end

  bfea_pkg::rsp_t rsp_hold_q;
  bfea_pkg::rsp_t rsp_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      rsp_hold_q.status         <= status_c;
      rsp_hold_q.user_address   <= uaddr_c;
      rsp_hold_q.granted_length <= glen_c;
    end
    if (ctrl_i.rsp_load) begin
      rsp_q <= rsp_hold_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= {{(bfea_pkg::MaxExtents-1){1'b0}}, 1'b1};
      init_q      <= 1'b1;
      out_valid_o <= 1'b0;
    end else begin
      valid_q <= valid_d;
      init_q  <= 1'b0;
      if (ctrl_i.rsp_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

[design/bfea_checker.sv]
// port-level checks for the extent allocator
// depends on bfea_pkg and best_fit_extent_allocator_unit

module bfea_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input bfea_pkg::rsp_t out_data_o
);

  // no new transfer in right after one was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("back-to-back input transfer");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // a result does not rise right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result too early");

  // successful allocate grants at least the minimum block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == bfea_pkg::StatusOk
      && out_data_o.granted_length != '0
    |-> out_data_o.granted_length >= 17'(bfea_pkg::MinBlockBytes))
    else $error("grant below minimum block");

endmodule

bind best_fit_extent_allocator_unit bfea_checker u_bfea_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[test/tb_best_fit_extent_allocator_unit.sv]
// self-checking testbench for best_fit_extent_allocator_unit: directed table then random
// allocate/free traffic, every result checked against a behavioral free-extent table model
// depends on bfea_pkg and best_fit_extent_allocator_unit

module tb_best_fit_extent_allocator_unit;

  localparam int unsigned AddrW = bfea_pkg::AddrW;
  localparam int unsigned LenW = bfea_pkg::LenW;
  localparam int unsigned MaxExtents = bfea_pkg::MaxExtents;
  localparam int unsigned PoolBytes = bfea_pkg::PoolBytes;
  localparam int unsigned HeaderBytes = bfea_pkg::HeaderBytes;
  localparam int unsigned MinBlockBytes = bfea_pkg::MinBlockBytes;

  localparam int unsigned NumRandom = 985;
  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  typedef struct {
    bfea_pkg::req_t req;
    logic has_rsp;
    bfea_pkg::rsp_t rsp;
  } vector_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  bfea_pkg::req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  bfea_pkg::rsp_t out_data_o;

  best_fit_extent_allocator_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  logic [AddrW-1:0] ext_start [MaxExtents];
  logic [LenW-1:0]  ext_len   [MaxExtents];
  logic             ext_vld   [MaxExtents];

  bfea_pkg::rsp_t rsp_queue [$];
  logic fixed_queue [$];
  bfea_pkg::rsp_t fixed_rsp_queue [$];
  bfea_pkg::rsp_t live_blocks [$];
  int   num_errors;
  logic stim_done;
  logic long_stall;
  vector_t directed [$];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void reset_table();
    for (int i = 0; i < MaxExtents; i++) begin
      ext_start[i] = '0;
      ext_len[i]   = '0;
      ext_vld[i]   = 1'b0;
    end
    ext_len[0] = LenW'(PoolBytes);
    ext_vld[0] = 1'b1;
  endfunction

  function automatic bfea_pkg::rsp_t allocate_block(logic [LenW-1:0] req_size);
    bfea_pkg::rsp_t r;
    int unsigned need;
    int best;
    r = '0;
    best = -1;
    need = req_size + HeaderBytes;
    if (need < MinBlockBytes) need = MinBlockBytes;
    for (int i = 0; i < MaxExtents; i++) begin
      if (ext_vld[i] && ext_len[i] >= need && (best < 0 || ext_len[i] < ext_len[best]))
        best = i;
    end
    if (best < 0) begin
      r.status = bfea_pkg::StatusNoFit;
      return r;
    end
    r.status = bfea_pkg::StatusOk;
    r.user_address = ext_start[best] + AddrW'(HeaderBytes);
    r.granted_length = LenW'(need);
    ext_start[best] = ext_start[best] + AddrW'(need);
    ext_len[best] = ext_len[best] - LenW'(need);
    if (ext_len[best] == 0) ext_vld[best] = 1'b0;
    return r;
  endfunction

  function automatic logic [LenW-1:0] clamp_len(int unsigned v);
    return (v > 32'h1FFFF) ? 17'h1FFFF : LenW'(v);
  endfunction

  function automatic bfea_pkg::rsp_t release_block(logic [AddrW-1:0] addr,
                                                   logic [LenW-1:0] len);
    bfea_pkg::rsp_t r;
    logic [AddrW-1:0] start;
    int unsigned fin;
    int left, right, slot;
    int unsigned total;
    r = '0;
    left = -1;
    right = -1;
    slot = -1;
    if (addr == 0) begin
      r.status = bfea_pkg::StatusNullFree;
      return r;
    end
    r.status = bfea_pkg::StatusOk;
    if (len == 0) return r;
    start = addr - AddrW'(HeaderBytes);
    fin = start + len;
    for (int i = 0; i < MaxExtents; i++) begin
      if (!ext_vld[i]) begin
        if (slot < 0) slot = i;
      end else begin
        if (left < 0 && (32'(ext_start[i]) + 32'(ext_len[i])) == 32'(start)) left = i;
        if (right < 0 && ext_start[i] == fin) right = i;
      end
    end
    if (left >= 0) begin
      total = ext_len[left] + len;
      if (right >= 0) begin
        total += ext_len[right];
        ext_vld[right] = 1'b0;
      end
      ext_len[left] = clamp_len(total);
    end else if (right >= 0) begin
      ext_start[right] = start;
      ext_len[right] = clamp_len(ext_len[right] + len);
    end else if (slot < 0) begin
      r.status = bfea_pkg::StatusFull;
    end else begin
      ext_start[slot] = start;
      ext_len[slot] = len;
      ext_vld[slot] = 1'b1;
    end
    return r;
  endfunction

  function automatic bfea_pkg::rsp_t predict_rsp(bfea_pkg::req_t req);
    if (req.mode == ModeAlloc) return allocate_block(req.request_size);
    return release_block(req.block_address, req.block_length);
  endfunction

  function automatic bfea_pkg::req_t alloc_req(logic [LenW-1:0] sz);
    bfea_pkg::req_t q;
    q = '0;
    q.mode = ModeAlloc;
    q.request_size = sz;
    q.block_address = AddrW'($urandom);
    q.block_length = LenW'($urandom);
    return q;
  endfunction

  function automatic bfea_pkg::req_t free_req(logic [AddrW-1:0] addr, logic [LenW-1:0] len);
    bfea_pkg::req_t q;
    q = '0;
    q.mode = ModeFree;
    q.request_size = LenW'($urandom);
    q.block_address = addr;
    q.block_length = len;
    return q;
  endfunction

  function automatic void add_row(bfea_pkg::req_t q, logic has, bfea_pkg::rsp_t r);
    vector_t v;
    v.req = q;
    v.has_rsp = has;
    v.rsp = r;
    directed.push_back(v);
  endfunction

  function automatic bfea_pkg::rsp_t mk_rsp(logic [1:0] st, logic [AddrW-1:0] a,
                                            logic [LenW-1:0] l);
    bfea_pkg::rsp_t r;
    r.status = st;
    r.user_address = a;
    r.granted_length = l;
    return r;
  endfunction

  task automatic send_item(bfea_pkg::req_t q, logic has, bfea_pkg::rsp_t fixed);
    bfea_pkg::rsp_t r;
    int gap;
    gap = $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= q;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = predict_rsp(q);
    rsp_queue.push_back(r);
    fixed_queue.push_back(has);
    fixed_rsp_queue.push_back(fixed);
    if (q.mode == ModeAlloc && r.status == bfea_pkg::StatusOk) live_blocks.push_back(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (rsp_queue.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    bfea_pkg::req_t q;
    bfea_pkg::rsp_t blk;
    int k;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    num_errors = 0;
    stim_done = 1'b0;
    long_stall = 1'b0;
    reset_table();

    // after reset, extremes and special cases
    add_row(alloc_req(17'd0), 1'b1, mk_rsp(bfea_pkg::StatusOk, 16'd8, 17'd24));
    add_row(alloc_req(17'd16), 1'b1, mk_rsp(bfea_pkg::StatusOk, 16'd32, 17'd24));
    add_row(alloc_req(17'd17), 1'b1, mk_rsp(bfea_pkg::StatusOk, 16'd56, 17'd25));
    add_row(alloc_req(17'd65536), 1'b1, mk_rsp(bfea_pkg::StatusNoFit, 16'd0, 17'd0));
    add_row(alloc_req(17'h1FFFF), 1'b1, mk_rsp(bfea_pkg::StatusNoFit, 16'd0, 17'd0));
    add_row(free_req(16'd0, 17'd24), 1'b1, mk_rsp(bfea_pkg::StatusNullFree, 16'd0, 17'd0));
    add_row(free_req(16'd0, 17'h1FFFF), 1'b1,
            mk_rsp(bfea_pkg::StatusNullFree, 16'd0, 17'd0));
    add_row(free_req(16'd32, 17'd0), 1'b1, mk_rsp(bfea_pkg::StatusOk, 16'd0, 17'd0));
    add_row(free_req(16'd32, 17'd24), 1'b0, '0);
    add_row(free_req(16'd8, 17'd24), 1'b0, '0);
    add_row(free_req(16'd56, 17'd25), 1'b0, '0);
    add_row(alloc_req(17'd65528), 1'b1, mk_rsp(bfea_pkg::StatusOk, 16'd8, 17'd65536));
    add_row(alloc_req(17'd0), 1'b1, mk_rsp(bfea_pkg::StatusNoFit, 16'd0, 17'd0));
    add_row(free_req(16'd4, 17'd100), 1'b0, '0);
    add_row(free_req(16'hFFFF, 17'h1FFFF), 1'b0, '0);
    add_row(free_req(16'd4, 17'h1FFFF), 1'b0, '0);
    add_row(free_req(16'd1000, 17'd50), 1'b0, '0);
    add_row(free_req(16'd1000, 17'd50), 1'b0, '0);
    add_row(alloc_req(17'd30), 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed[i]) send_item(directed[i].req, directed[i].has_rsp, directed[i].rsp);
    drain();
    repeat (40) @(posedge clk_i);

    // fill table with scattered single blocks to reach table full
    rst_ni <= 1'b1;
    for (int i = 0; i < 40; i++) begin
      q = free_req(AddrW'(16'd2000 + i * 100), 17'd10);
      send_item(q, 1'b0, '0);
    end
    drain();

    // receiver holds off while the sender keeps offering
    long_stall = 1'b1;
    for (int i = 0; i < 6; i++) send_item(alloc_req(LenW'($urandom_range(0, 64))), 1'b0, '0);
    drain();
    long_stall = 1'b0;

    for (int n = 0; n < NumRandom; n++) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        q = alloc_req(($urandom_range(0, 9) == 0) ? LenW'($urandom) :
                      LenW'($urandom_range(0, 2000)));
      end else if (k < 85 && live_blocks.size() != 0) begin
        k = $urandom_range(0, live_blocks.size() - 1);
        blk = live_blocks[k];
        live_blocks.delete(k);
        q = free_req(blk.user_address, blk.granted_length);
      end else if (k < 90) begin
        q = free_req(16'd0, LenW'($urandom));
      end else begin
        q = free_req(AddrW'($urandom), ($urandom_range(0, 3) == 0) ? LenW'($urandom) :
                     LenW'($urandom_range(0, 300)));
      end
      send_item(q, 1'b0, '0);
      if (n == NumRandom / 2) drain();
    end
    drain();
    stim_done = 1'b1;
  end

  initial begin
    int hold;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        while (long_stall && rsp_queue.size() == 0) @(posedge clk_i);
      end
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      out_ready_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    bfea_pkg::rsp_t exp_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsp_queue.size() == 0) begin
        $error("unexpected transfer: status %0d", out_data_o.status);
        num_errors++;
      end else begin
        exp_rsp = rsp_queue.pop_front();
        if (fixed_queue.pop_front()) begin
          if (fixed_rsp_queue[0] != exp_rsp) begin
            $error("table row disagrees with prediction");
            num_errors++;
          end
        end
        void'(fixed_rsp_queue.pop_front());
        if (out_data_o.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, out_data_o.status);
          num_errors++;
        end
        if (out_data_o.user_address !== exp_rsp.user_address) begin
          $error("user_address: expected %0d, got %0d", exp_rsp.user_address,
                 out_data_o.user_address);
          num_errors++;
        end
        if (out_data_o.granted_length !== exp_rsp.granted_length) begin
          $error("granted_length: expected %0d, got %0d", exp_rsp.granted_length,
                 out_data_o.granted_length);
          num_errors++;
        end
      end
    end
  end

  initial begin
    @(posedge stim_done);
    while (rsp_queue.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (num_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
